// File: hdl/alps_pkg.sv
// ----------------------------------------------------------------------------
// alps_pkg: shared types and constants of the averaged level to PWM block
// Field widths, window geometry, serial unit codes and register indexes.
// ----------------------------------------------------------------------------
package alps_pkg;

  // Field widths.
  localparam int unsigned LEVEL_W     = 10;
  localparam int unsigned DELAY_W     = 16;

  // Averaging window; its depth is a power of two so the mean is a shift.
  localparam int unsigned WINDOW_LOG2 = 4;
  localparam int unsigned WINDOW      = 1 << WINDOW_LOG2;
  localparam int unsigned SUM_W       = LEVEL_W + WINDOW_LOG2;

  // Serial multiply/divide unit.
  localparam int unsigned PROD_W      = 2 * LEVEL_W;
  localparam int unsigned CNT_W       = $clog2(PROD_W + 1);

  // Division of a LEVEL_W-bit gap by ten: (gap * 205) >> 11 is exact below 1024.
  localparam int unsigned RECIP_TEN   = 205;
  localparam int unsigned RECIP_W     = 8;
  localparam int unsigned RECIP_SHIFT = 11;

  // Configuration port.
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 3;

  localparam logic [LEVEL_W-1:0] IN_LOW_RST     = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] IN_HIGH_RST    = LEVEL_W'(1023);
  localparam logic [LEVEL_W-1:0] OUT_LOW_RST    = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] OUT_HIGH_RST   = LEVEL_W'(1023);
  localparam logic [DELAY_W-1:0] BASE_DELAY_RST = DELAY_W'(1000);

  typedef enum logic [IDX_W-1:0] {
    REG_IN_LOW     = 3'd0,
    REG_IN_HIGH    = 3'd1,
    REG_OUT_LOW    = 3'd2,
    REG_OUT_HIGH   = 3'd3,
    REG_BASE_DELAY = 3'd4
  } reg_idx_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_MAP  = 3'd1,
    ST_STEP = 3'd2,
    ST_OUT  = 3'd3
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MD_IDLE = 2'd0,
    MD_MUL  = 2'd1,
    MD_DIV  = 2'd2,
    MD_DONE = 2'd3
  } md_state_e;

  typedef struct packed {
    logic               operation;
    logic [LEVEL_W-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty_level;
    logic [DELAY_W-1:0] sample_delay;
    logic [LEVEL_W-1:0] window_average;
  } out_rsp_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] in_low;
    logic [LEVEL_W-1:0] in_high;
    logic [LEVEL_W-1:0] out_low;
    logic [LEVEL_W-1:0] out_high;
    logic [DELAY_W-1:0] base_delay;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] mcand;
    logic [LEVEL_W-1:0] mplier;
    logic [LEVEL_W-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quot;
    logic               rem_nz;
  } md_rsp_t;

endpackage

// File: hdl/alps_regs.sv
// ----------------------------------------------------------------------------
// alps_regs: configuration register file
// Holds the map ranges and the base delay behind an APB-style port.
// ----------------------------------------------------------------------------
module alps_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alps_pkg::ADDR_W-1:0]  paddr,
  input  logic [alps_pkg::DATA_W-1:0]  pwdata,
  output logic [alps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output alps_pkg::cfg_t               cfg_o
);

  alps_pkg::cfg_t     cfg_q, cfg_d;
  alps_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = alps_pkg::reg_idx_e'(paddr[alps_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        alps_pkg::REG_IN_LOW:     cfg_d.in_low     = pwdata[alps_pkg::LEVEL_W-1:0];
        alps_pkg::REG_IN_HIGH:    cfg_d.in_high    = pwdata[alps_pkg::LEVEL_W-1:0];
        alps_pkg::REG_OUT_LOW:    cfg_d.out_low    = pwdata[alps_pkg::LEVEL_W-1:0];
        alps_pkg::REG_OUT_HIGH:   cfg_d.out_high   = pwdata[alps_pkg::LEVEL_W-1:0];
        alps_pkg::REG_BASE_DELAY: cfg_d.base_delay = pwdata[alps_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      alps_pkg::REG_IN_LOW:     prdata = alps_pkg::DATA_W'(cfg_q.in_low);
      alps_pkg::REG_IN_HIGH:    prdata = alps_pkg::DATA_W'(cfg_q.in_high);
      alps_pkg::REG_OUT_LOW:    prdata = alps_pkg::DATA_W'(cfg_q.out_low);
      alps_pkg::REG_OUT_HIGH:   prdata = alps_pkg::DATA_W'(cfg_q.out_high);
      alps_pkg::REG_BASE_DELAY: prdata = alps_pkg::DATA_W'(cfg_q.base_delay);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_low     <= alps_pkg::IN_LOW_RST;
      cfg_q.in_high    <= alps_pkg::IN_HIGH_RST;
      cfg_q.out_low    <= alps_pkg::OUT_LOW_RST;
      cfg_q.out_high   <= alps_pkg::OUT_HIGH_RST;
      cfg_q.base_delay <= alps_pkg::BASE_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: hdl/alps_window.sv
// ----------------------------------------------------------------------------
// alps_window: sample ring and running sum
// Replaces the oldest sample on each push and keeps the sum of the ring.
// ----------------------------------------------------------------------------
module alps_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [alps_pkg::LEVEL_W-1:0]  sample_i,
  output logic [alps_pkg::SUM_W-1:0]    sum_o
);

  logic [alps_pkg::LEVEL_W-1:0]     ring_q [alps_pkg::WINDOW];
  logic [alps_pkg::WINDOW_LOG2-1:0] wp_q;
  logic [alps_pkg::SUM_W-1:0]       sum_q, sum_d;

  // The sum never exceeds WINDOW full-scale samples, so it cannot wrap.
  assign sum_d = sum_q - alps_pkg::SUM_W'(ring_q[wp_q]) + alps_pkg::SUM_W'(sample_i);
  assign sum_o = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < alps_pkg::WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      wp_q  <= '0;
      sum_q <= '0;
    end else if (push_i) begin
      ring_q[wp_q] <= sample_i;
      wp_q         <= wp_q + 1'b1;
      sum_q        <= sum_d;
    end
  end

endmodule

// File: hdl/alps_muldiv.sv
// ----------------------------------------------------------------------------
// alps_muldiv: bit-serial multiply then divide
// Forms mcand * mplier one bit per cycle, then divides by the divisor one
// quotient bit per cycle in the same shift register.
// ----------------------------------------------------------------------------
module alps_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  alps_pkg::md_req_t req_i,
  output alps_pkg::md_rsp_t rsp_o
);

  localparam int unsigned LW = alps_pkg::LEVEL_W;

  alps_pkg::md_state_e           state_q, state_d;
  logic [alps_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]                 hi_q, hi_d;
  logic [LW-1:0]                 lo_q, lo_d;
  logic [LW-1:0]                 rem_q, rem_d;
  logic [LW-1:0]                 a_q, a_d;
  logic [LW-1:0]                 div_q, div_d;
  logic [LW:0]                   add_sum;
  logic [LW:0]                   rem_sh;
  logic [LW:0]                   rem_diff;
  logic                          ge;
  logic                          done;

  // Adder of the multiply phase and subtractor of the divide phase.
  assign add_sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign rem_sh   = {rem_q, hi_q[LW-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign ge       = (rem_sh >= {1'b0, div_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    rem_d   = rem_q;
    a_d     = a_q;
    div_d   = div_q;
    done    = 1'b0;
    case (state_q)
      alps_pkg::MD_IDLE: begin
        if (req_i.start) begin
          a_d     = req_i.mcand;
          lo_d    = req_i.mplier;
          div_d   = req_i.divisor;
          hi_d    = '0;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = alps_pkg::MD_MUL;
        end
      end
      alps_pkg::MD_MUL: begin
        // Add-and-shift right: the product builds up in {hi, lo}.
        hi_d  = add_sum[LW:1];
        lo_d  = {add_sum[0], lo_q[LW-1:1]};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == alps_pkg::CNT_W'(LW - 1)) begin
          cnt_d   = '0;
          state_d = alps_pkg::MD_DIV;
        end
      end
      alps_pkg::MD_DIV: begin
        // Restoring division; quotient bits enter at the bottom of {hi, lo}.
        rem_d        = ge ? rem_diff[LW-1:0] : rem_sh[LW-1:0];
        {hi_d, lo_d} = {hi_q[LW-2:0], lo_q, ge};
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == alps_pkg::CNT_W'(alps_pkg::PROD_W - 1)) begin
          cnt_d   = '0;
          state_d = alps_pkg::MD_DONE;
        end
      end
      alps_pkg::MD_DONE: begin
        done    = 1'b1;
        state_d = alps_pkg::MD_IDLE;
      end
      default: state_d = alps_pkg::MD_IDLE;
    endcase
  end

  // The quotient never exceeds the multiplicand, so the low half holds it.
  // Fields in order: done, quotient, remainder nonzero.
  assign rsp_o = {done, lo_q, |rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alps_pkg::MD_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    rem_q <= rem_d;
    a_q   <= a_d;
    div_q <= div_d;
  end

endmodule

// File: hdl/averaged_level_to_pwm_slew.sv
// ----------------------------------------------------------------------------
// averaged_level_to_pwm_slew: moving average, linear map and slew limiter
// Turns converter samples into a slew-limited PWM compare value.
// ----------------------------------------------------------------------------
// A request is either a sample, which enters a 16-deep averaging ring, or an
// update tick, which maps the ring's mean linearly from [in_low, in_high]
// onto [out_low, out_high] and moves the duty a tenth of the way (at least
// one count) toward that target. Every request yields one response carrying
// the duty, the sample delay (base_delay minus half the duty, floored at
// zero) and the current window mean. A sample request goes from acceptance
// to the output state, which loads the response register, and then back
// to idle. A tick with a non-empty input range first runs the bit-serial
// multiply and divide unit that evaluates the map, then collects the
// quotient as the target, takes the slew step, loads the response and
// returns to idle. With an empty or reversed input range the map is
// skipped and the target is out_low. The output state waits while the
// output register still holds an unaccepted response.
// One request is worked on at a time; a finished response waits in its own
// output register, so the next request can be accepted while the previous
// response is stalled.
// Configuration is to be written through the APB-style port only while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module averaged_level_to_pwm_slew (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  alps_pkg::in_req_t            in_req_i,
  // Response channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output alps_pkg::out_rsp_t           out_rsp_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alps_pkg::ADDR_W-1:0]  paddr,
  input  logic [alps_pkg::DATA_W-1:0]  pwdata,
  output logic [alps_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned LW = alps_pkg::LEVEL_W;
  localparam int unsigned PW = LW + alps_pkg::RECIP_W;

  alps_pkg::cfg_t              cfg;
  alps_pkg::md_req_t           md_req;
  alps_pkg::md_rsp_t           md_rsp;
  alps_pkg::ctrl_state_e       state_q, state_d;
  alps_pkg::out_rsp_t          out_rsp_q, out_rsp_d;
  logic                        out_valid_q, out_valid_d;
  logic [LW-1:0]               duty_q, duty_d;
  logic [LW-1:0]               target_q, target_d;
  logic                        neg_q, neg_d;

  logic                        in_acc;
  logic                        is_tick;
  logic                        push;
  logic [alps_pkg::SUM_W-1:0]  sum;
  logic [LW-1:0]               avg;
  logic                        span_ok;
  logic [LW-1:0]               clamped;
  logic [LW-1:0]               in_off;
  logic [LW-1:0]               span;
  logic                        out_neg;
  logic [LW-1:0]               out_mag;
  logic [LW:0]                 q_adj;
  logic [LW:0]                 tgt_sum;
  logic                        up;
  logic [LW-1:0]               gap;
  logic [PW-1:0]               prod;
  logic [LW-1:0]               step;
  logic [alps_pkg::DELAY_W-1:0] half;
  logic [alps_pkg::DELAY_W-1:0] delay;
  logic                        load_out;

  alps_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  alps_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (in_req_i.sample_value),
    .sum_o    (sum)
  );

  alps_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Acceptance. Only idle takes a request; the output register decouples
  // the response side.
  assign in_ready_o = (state_q == alps_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign is_tick    = (alps_pkg::op_e'(in_req_i.operation) == alps_pkg::OP_TICK);
  assign push       = in_acc & ~is_tick;

  // Map operands: the mean clamped into the input range, its offset from
  // in_low, the span, and the magnitude and sign of the output range.
  assign avg     = sum[alps_pkg::SUM_W-1:alps_pkg::WINDOW_LOG2];
  assign span_ok = (cfg.in_high > cfg.in_low);
  assign clamped = (avg < cfg.in_low)  ? cfg.in_low  :
                   (avg > cfg.in_high) ? cfg.in_high : avg;
  assign in_off  = clamped - cfg.in_low;
  assign span    = cfg.in_high - cfg.in_low;
  assign out_neg = (cfg.out_high < cfg.out_low);
  assign out_mag = out_neg ? (cfg.out_low - cfg.out_high) : (cfg.out_high - cfg.out_low);

  // Fields in order: start, multiplicand, multiplier, divisor.
  assign md_req = {in_acc & is_tick & span_ok, out_mag, in_off, span};

  // The map floors toward minus infinity, so a falling output range with a
  // nonzero remainder steps one count further from out_low.
  assign q_adj   = {1'b0, md_rsp.quot} + (LW + 1)'(neg_q & md_rsp.rem_nz);
  assign tgt_sum = neg_q ? ({1'b0, cfg.out_low} - q_adj) : ({1'b0, cfg.out_low} + q_adj);

  // Slew step: a tenth of the gap by reciprocal multiplication, at least 1.
  assign up   = (target_q > duty_q);
  assign gap  = up ? (target_q - duty_q) : (duty_q - target_q);
  assign prod = PW'(gap) * PW'(alps_pkg::RECIP_TEN);
  assign step = (prod[PW-1:alps_pkg::RECIP_SHIFT] == '0) ? LW'(1) :
                LW'(prod[PW-1:alps_pkg::RECIP_SHIFT]);

  // Sample delay, saturating at zero.
  assign half  = alps_pkg::DELAY_W'(duty_q[LW-1:1]);
  assign delay = (cfg.base_delay > half) ? (cfg.base_delay - half) : '0;

  assign load_out = (state_q == alps_pkg::ST_OUT) & (~out_valid_q | out_ready_i);

  always_comb begin
    state_d  = state_q;
    duty_d   = duty_q;
    target_d = target_q;
    neg_d    = neg_q;
    case (state_q)
      alps_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_tick) begin
            neg_d = out_neg;
            if (span_ok) begin
              state_d = alps_pkg::ST_MAP;
            end else begin
              // Empty or reversed input range: the target is out_low.
              target_d = cfg.out_low;
              state_d  = alps_pkg::ST_STEP;
            end
          end else begin
            state_d = alps_pkg::ST_OUT;
          end
        end
      end
      alps_pkg::ST_MAP: begin
        if (md_rsp.done) begin
          target_d = tgt_sum[LW-1:0];
          state_d  = alps_pkg::ST_STEP;
        end
      end
      alps_pkg::ST_STEP: begin
        if (target_q != duty_q) begin
          duty_d = up ? (duty_q + step) : (duty_q - step);
        end
        state_d = alps_pkg::ST_OUT;
      end
      alps_pkg::ST_OUT: begin
        if (load_out) begin
          state_d = alps_pkg::ST_IDLE;
        end
      end
      default: state_d = alps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d              = 1'b1;
      out_rsp_d.duty_level     = duty_q;
      out_rsp_d.sample_delay   = delay;
      out_rsp_d.window_average = avg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      duty_q      <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    target_q  <= target_d;
    neg_q     <= neg_d;
  end

  // The duty register only moves in the slew step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(duty_q) |-> $past(state_q) == alps_pkg::ST_STEP)
    else $error("duty changed outside the slew step");

  // A new response only appears when the output stage loads one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == alps_pkg::ST_OUT)
    else $error("response raised outside the output state");

  // The serial unit finishes only while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> state_q == alps_pkg::ST_MAP)
    else $error("map result arrived while the controller was not waiting");

  // A tick with a non-empty input range always goes through the map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |=> state_q == alps_pkg::ST_MAP)
    else $error("map started without the controller following it");

endmodule

// File: verif/alps_response_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alps_response_check: filter, map and slew prediction with response checking
// Mirrors register writes, predicts one response per accepted request and
// compares every accepted response field by field in arrival order.
// ----------------------------------------------------------------------------
module alps_response_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  alps_pkg::in_req_t             in_req_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  alps_pkg::out_rsp_t            out_rsp_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [alps_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [alps_pkg::DATA_W-1:0]   pwdata_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int SLEW_DIVISOR = 10;
  localparam int REPORT_LIMIT = 10;

  alps_pkg::cfg_t                   cfg;
  logic [alps_pkg::LEVEL_W-1:0]     level_hist [alps_pkg::WINDOW];
  logic [alps_pkg::WINDOW_LOG2-1:0] oldest_slot;
  logic [alps_pkg::SUM_W-1:0]       level_sum;
  logic [alps_pkg::LEVEL_W-1:0]     duty_now;
  alps_pkg::out_rsp_t               duty_rsp_q [$];
  int                               fault_total;

  // Floor of the linear map; an empty or reversed input range pins the
  // target to out_low.
  function automatic int map_level(int avg);
    int span, v, dout, num, q;
    span = int'(cfg.in_high) - int'(cfg.in_low);
    if (span <= 0) return int'(cfg.out_low);
    v = avg;
    if (v < int'(cfg.in_low)) v = int'(cfg.in_low);
    if (v > int'(cfg.in_high)) v = int'(cfg.in_high);
    dout = int'(cfg.out_high) - int'(cfg.out_low);
    num  = dout * (v - int'(cfg.in_low));
    if (num >= 0) q = num / span;
    else q = -((-num + span - 1) / span);
    return int'(cfg.out_low) + q;
  endfunction

  task automatic advance_filter(input alps_pkg::in_req_t req,
                                output alps_pkg::out_rsp_t rsp);
    int avg, goal, stride, half;
    if (req.operation == alps_pkg::OP_SAMPLE) begin
      level_sum = level_sum - level_hist[oldest_slot] + req.sample_value;
      level_hist[oldest_slot] = req.sample_value;
      oldest_slot = oldest_slot + 1'b1;
    end
    avg = int'(level_sum >> alps_pkg::WINDOW_LOG2);
    if (req.operation == alps_pkg::OP_TICK) begin
      goal = map_level(avg);
      if (goal > int'(duty_now)) begin
        stride = (goal - int'(duty_now)) / SLEW_DIVISOR;
        if (stride < 1) stride = 1;
        duty_now = duty_now + alps_pkg::LEVEL_W'(stride);
      end else if (goal < int'(duty_now)) begin
        stride = (int'(duty_now) - goal) / SLEW_DIVISOR;
        if (stride < 1) stride = 1;
        duty_now = duty_now - alps_pkg::LEVEL_W'(stride);
      end
    end
    half = int'(duty_now >> 1);
    rsp.duty_level     = duty_now;
    rsp.sample_delay   = (int'(cfg.base_delay) > half) ?
                         alps_pkg::DELAY_W'(int'(cfg.base_delay) - half) : '0;
    rsp.window_average = alps_pkg::LEVEL_W'(avg);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      if (fault_total < REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alps_pkg::out_rsp_t fresh;
    alps_pkg::out_rsp_t want;
    if (!rst_ni) begin
      cfg = '{in_low: alps_pkg::IN_LOW_RST, in_high: alps_pkg::IN_HIGH_RST,
              out_low: alps_pkg::OUT_LOW_RST, out_high: alps_pkg::OUT_HIGH_RST,
              base_delay: alps_pkg::BASE_DELAY_RST};
      foreach (level_hist[i]) level_hist[i] = '0;
      oldest_slot = '0;
      level_sum   = '0;
      duty_now    = '0;
      duty_rsp_q.delete();
      fault_total = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[alps_pkg::ADDR_W-1:2])
          alps_pkg::REG_IN_LOW:     cfg.in_low     = pwdata_i[alps_pkg::LEVEL_W-1:0];
          alps_pkg::REG_IN_HIGH:    cfg.in_high    = pwdata_i[alps_pkg::LEVEL_W-1:0];
          alps_pkg::REG_OUT_LOW:    cfg.out_low    = pwdata_i[alps_pkg::LEVEL_W-1:0];
          alps_pkg::REG_OUT_HIGH:   cfg.out_high   = pwdata_i[alps_pkg::LEVEL_W-1:0];
          alps_pkg::REG_BASE_DELAY: cfg.base_delay = pwdata_i[alps_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_filter(in_req_i, fresh);
        duty_rsp_q.push_back(fresh);
      end
      if (out_valid_i && out_ready_i) begin
        if (duty_rsp_q.size() == 0) begin
          if (fault_total < REPORT_LIMIT)
            $display("%0t ns: response with none outstanding: duty %0d delay %0d avg %0d",
                     $realtime, out_rsp_i.duty_level, out_rsp_i.sample_delay,
                     out_rsp_i.window_average);
          fault_total++;
        end else begin
          want = duty_rsp_q.pop_front();
          check_field("duty_level", want.duty_level, out_rsp_i.duty_level);
          check_field("sample_delay", want.sample_delay, out_rsp_i.sample_delay);
          check_field("window_average", want.window_average, out_rsp_i.window_average);
        end
      end
    end
    fail_count_o <= fault_total;
    pending_o    <= duty_rsp_q.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for averaged_level_to_pwm_slew
// Drives samples and update ticks under several register settings with
// random gaps on both channels; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  // A tick keeps the block busy while the map runs, so after the last response
  // a margin beyond the longest request is left before any register write.
  localparam int DRAIN_GAP   = 40;
  localparam int IDLE_PCT    = 22;
  localparam int TICK_PCT    = 35;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 56;
  // Indexes past the last register; writes there must change nothing.
  localparam logic [alps_pkg::IDX_W-1:0] SPARE_IDX_A = 3'd5;
  localparam logic [alps_pkg::IDX_W-1:0] SPARE_IDX_B = 3'd7;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  alps_pkg::in_req_t            in_req    = '0;
  logic                         in_ready;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  alps_pkg::out_rsp_t           out_rsp;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [alps_pkg::ADDR_W-1:0]  paddr     = '0;
  logic [alps_pkg::DATA_W-1:0]  pwdata    = '0;
  logic [alps_pkg::DATA_W-1:0]  prdata;
  logic                         pready;

  // While calm is set neither channel inserts gaps.
  logic               calm      = 1'b0;
  int                 fail_count;
  int                 pending;
  int                 sample_count  = 0;
  int                 tick_count    = 0;
  int                 setting_count = 0;

  always #2 clk = ~clk;

  averaged_level_to_pwm_slew uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  alps_response_check response_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // The response side stalls at random in roughly a fifth of the cycles.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offers one request, possibly after a few idle cycles, and returns at the
  // edge where it is taken. Within this task valid is only lowered in the idle
  // loop, so it never gets two assignments in one time step.
  task automatic send_req(input alps_pkg::op_e op,
                          input logic [alps_pkg::LEVEL_W-1:0] value);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_req.operation       <= op;
    in_req.sample_value    <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == alps_pkg::OP_TICK) tick_count++;
    else sample_count++;
  endtask

  // Lets every outstanding response come back, then waits out the block's
  // longest request so that the next register write finds it idle. The first
  // edge lets the checker count the request accepted last.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the edge
  // that ends the access cycle.
  task automatic write_reg(input logic [alps_pkg::IDX_W-1:0] idx,
                           input logic [alps_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= alps_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [alps_pkg::DATA_W-1:0] lo,
                              input logic [alps_pkg::DATA_W-1:0] hi,
                              input logic [alps_pkg::DATA_W-1:0] olo,
                              input logic [alps_pkg::DATA_W-1:0] ohi,
                              input logic [alps_pkg::DATA_W-1:0] base);
    write_reg(alps_pkg::REG_IN_LOW, lo);
    write_reg(alps_pkg::REG_IN_HIGH, hi);
    write_reg(alps_pkg::REG_OUT_LOW, olo);
    write_reg(alps_pkg::REG_OUT_HIGH, ohi);
    write_reg(alps_pkg::REG_BASE_DELAY, base);
    setting_count++;
  endtask

  initial begin
    int lvl, val, lo, hi;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset setting. A tick on the cleared ring finds
    // the duty already at its target, so nothing moves.
    send_req(alps_pkg::OP_TICK, '0);
    // Full-scale samples half fill the ring, then two ticks slew upward.
    repeat (8) send_req(alps_pkg::OP_SAMPLE, 10'h3FF);
    send_req(alps_pkg::OP_TICK, 10'h3FF);
    send_req(alps_pkg::OP_TICK, 10'h155);
    // Lowest value and alternating bit patterns.
    send_req(alps_pkg::OP_SAMPLE, 10'h000);
    send_req(alps_pkg::OP_SAMPLE, 10'h2AA);
    send_req(alps_pkg::OP_SAMPLE, 10'h155);
    send_req(alps_pkg::OP_TICK, 10'h2AA);

    // Equal input ends: the target collapses to out_low.
    drain();
    load_setting(500, 500, 300, 900, 200);
    send_req(alps_pkg::OP_TICK, '0);
    send_req(alps_pkg::OP_TICK, '0);
    // Input ends swapped: treated the same as an empty range.
    drain();
    load_setting(800, 100, 700, 20, 65535);
    send_req(alps_pkg::OP_TICK, '0);
    // Writes past the last register are dropped.
    drain();
    write_reg(SPARE_IDX_A, 32'hFFFF_FFFF);
    write_reg(SPARE_IDX_B, 32'h0000_0000);
    send_req(alps_pkg::OP_SAMPLE, 10'd512);
    send_req(alps_pkg::OP_TICK, '0);

    // Random part: each phase holds one register setting. Samples mostly
    // wander around a slowly drifting level so the mean and the duty travel
    // across the whole range; the rest are arbitrary values.
    lvl = $urandom_range(0, 1023);
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        // Falling map with a zero base delay, which pins the delay at zero.
        0: load_setting(0, 1023, 1023, 0, 0);
        // All-ones writes exercise the masking to register width.
        1: load_setting(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Fully reversed input range with the highest out_low.
        2: load_setting(1023, 0, 1023, 0, 300);
        // Narrow input window, high gain; this phase also runs gap-free.
        3: load_setting(400, 440, 0, 1023, 600);
        default: begin
          lo = $urandom_range(0, 1023);
          hi = $urandom_range(0, 1023);
          if (lo > hi && $urandom_range(99) < 70) begin
            val = lo;
            lo  = hi;
            hi  = val;
          end
          load_setting(lo, hi, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       ($urandom_range(1) != 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 600));
        end
      endcase
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 3) lvl = $urandom_range(0, 1023);
        if ($urandom_range(99) < TICK_PCT) begin
          send_req(alps_pkg::OP_TICK, alps_pkg::LEVEL_W'($urandom_range(0, 1023)));
        end else if ($urandom_range(99) < 70) begin
          val = lvl + int'($urandom_range(0, 64)) - 32;
          if (val < 0) val = 0;
          if (val > 1023) val = 1023;
          send_req(alps_pkg::OP_SAMPLE, alps_pkg::LEVEL_W'(val));
        end else begin
          send_req(alps_pkg::OP_SAMPLE, alps_pkg::LEVEL_W'($urandom_range(0, 1023)));
        end
      end
      calm = 1'b0;
    end

    drain();
    $display("Covered %0d sample and %0d tick requests over %0d register settings,",
             sample_count, tick_count, setting_count);
    $display("including empty, reversed, narrow and full-scale ranges and masked writes.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Far beyond the slowest legal run, which stays well under 100 us.
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
hdl/alps_pkg.sv
hdl/alps_regs.sv
hdl/alps_window.sv
hdl/alps_muldiv.sv
hdl/averaged_level_to_pwm_slew.sv
verif/alps_response_check.sv
verif/testbench.sv
